// ===== rtl/pci_host_bridge_config_shadow_defines.svh =====
// assertion macros shared by the host bridge checker
`ifndef PCI_HOST_BRIDGE_CONFIG_SHADOW_DEFINES_SVH
`define PCI_HOST_BRIDGE_CONFIG_SHADOW_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet while arst_n is low
`define PHB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet while arst_n is low
`define PHB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// implication with a delayed consequent, sampled on clk, quiet while arst_n is low
`define PHB_ASSERT_TWO(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##2 (cons)) \
		else $error(msg);

`endif

// ===== rtl/phb_pkg.sv =====
// types, register addresses and helper functions of the host bridge config space
package phb_pkg;

	localparam int ADDR_W = 8;
	localparam int DATA_W = 8;
	localparam int DEPTH  = 256;
	localparam int SEG_W  = 4;

	// number of shadow segments that can ever go internal
	localparam int SHADOW_SEGMENTS = 4;

	typedef enum logic {
		REQ_READ  = 1'b0,
		REQ_WRITE = 1'b1
	} req_kind_t;

	// shadow mode held in register 0x53 bits 6:5
	typedef enum logic [1:0] {
		MODE_REXT_WINT = 2'd0,
		MODE_REXT_WEXT = 2'd1,
		MODE_RINT_WINT = 2'd2,
		MODE_RINT_WEXT = 2'd3
	} shadow_mode_t;

	// register addresses
	localparam logic [ADDR_W-1:0] ADDR_VID_LO = 8'h00;
	localparam logic [ADDR_W-1:0] ADDR_VID_HI = 8'h01;
	localparam logic [ADDR_W-1:0] ADDR_DID_LO = 8'h02;
	localparam logic [ADDR_W-1:0] ADDR_DID_HI = 8'h03;
	localparam logic [ADDR_W-1:0] ADDR_CMD_LO = 8'h04;
	localparam logic [ADDR_W-1:0] ADDR_CMD_HI = 8'h05;
	localparam logic [ADDR_W-1:0] ADDR_STS_LO = 8'h06;
	localparam logic [ADDR_W-1:0] ADDR_STS_HI = 8'h07;
	localparam logic [ADDR_W-1:0] ADDR_REV    = 8'h08;
	localparam logic [ADDR_W-1:0] ADDR_CLASS  = 8'h0B;
	localparam logic [ADDR_W-1:0] ADDR_CLS    = 8'h0C;
	localparam logic [ADDR_W-1:0] ADDR_HDR    = 8'h0E;
	localparam logic [ADDR_W-1:0] ADDR_RO_LO  = 8'h10;
	localparam logic [ADDR_W-1:0] ADDR_RO_HI  = 8'h4E;
	localparam logic [ADDR_W-1:0] ADDR_CFG50  = 8'h50;
	localparam logic [ADDR_W-1:0] ADDR_CFG51  = 8'h51;
	localparam logic [ADDR_W-1:0] ADDR_CFG52  = 8'h52;
	localparam logic [ADDR_W-1:0] ADDR_CFG53  = 8'h53;
	localparam logic [ADDR_W-1:0] ADDR_SHADOW = 8'h54;

	localparam logic [DATA_W-1:0] FUNC_ABSENT_DATA = 8'hFF;
	localparam logic [DATA_W-1:0] SHADOW_KEEP      = 8'hF0;

	typedef struct packed {
		logic              store;
		logic [DATA_W-1:0] value;
	} wr_filt_t;

	// value a byte holds after reset
	function automatic logic [DATA_W-1:0] reset_byte(input logic [ADDR_W-1:0] addr);
		logic [DATA_W-1:0] v;
		case (addr)
			ADDR_VID_LO: v = 8'h39;
			ADDR_VID_HI: v = 8'h10;
			ADDR_DID_LO: v = 8'h06;
			ADDR_DID_HI: v = 8'h04;
			ADDR_CMD_LO: v = 8'h07;
			ADDR_STS_LO: v = 8'h80;
			ADDR_STS_HI: v = 8'h02;
			ADDR_CLASS:  v = 8'h06;
			ADDR_CFG50:  v = 8'hBC;
			ADDR_CFG51:  v = 8'hFB;
			ADDR_CFG52:  v = 8'hAD;
			ADDR_CFG53:  v = 8'hFE;
			default:     v = '0;
		endcase
		return v;
	endfunction

	// write masking: read-only bytes, command and status forcing
	function automatic wr_filt_t write_filter(input logic [ADDR_W-1:0] addr,
			input logic [DATA_W-1:0] v);
		wr_filt_t f;
		f.store = 1'b1;
		f.value = v;
		case (addr) inside
			[ADDR_VID_LO:ADDR_DID_HI], [ADDR_REV:ADDR_CLS], ADDR_HDR,
			[ADDR_RO_LO:ADDR_RO_HI]: f.store = 1'b0;
			ADDR_CMD_LO: f.value = (v & 8'h42) | 8'h04;
			ADDR_CMD_HI: f.value = v & 8'h01;
			ADDR_STS_LO: f.value = '0;
			ADDR_STS_HI: f.value = 8'h02;
			default: f.value = v;
		endcase
		return f;
	endfunction

	// shadow map: bits 3:0 read internal, bits 7:4 write internal
	function automatic logic [2*SEG_W-1:0] build_map(input logic [1:0] mode,
			input logic [SEG_W-1:0] en);
		logic [SEG_W-1:0] rd;
		logic [SEG_W-1:0] wr;
		rd = '0;
		wr = '0;
		for (int d = 0; d < SEG_W; d++) begin
			if ((d < SHADOW_SEGMENTS) && en[d]) begin
				case (shadow_mode_t'(mode))
					MODE_REXT_WINT: wr[d] = 1'b1;
					MODE_RINT_WINT: begin
						rd[d] = 1'b1;
						wr[d] = 1'b1;
					end
					MODE_RINT_WEXT: rd[d] = 1'b1;
					default: ;
				endcase
			end
		end
		return {wr, rd};
	endfunction

endpackage

// ===== rtl/phb_req_if.sv =====
// request channel: one configuration access per transaction
interface phb_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [2:0] func_num;
	logic [7:0] reg_addr;
	logic [7:0] wdata;

	modport source (output valid, output req_type, output func_num, output reg_addr,
		output wdata, input ready);
	modport sink (input valid, input req_type, input func_num, input reg_addr,
		input wdata, output ready);
endinterface

// ===== rtl/phb_rsp_if.sv =====
// response channel: read byte and shadow map per transaction
interface phb_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] rdata;
	logic [3:0] seg_read_internal;
	logic [3:0] seg_write_internal;
	logic       map_updated;

	modport source (output valid, output rdata, output seg_read_internal,
		output seg_write_internal, output map_updated, input ready);
	modport sink (input valid, input rdata, input seg_read_internal,
		input seg_write_internal, input map_updated, output ready);
endinterface

// ===== rtl/phb_ram.sv =====
// generic single-clock ram, one write and one registered read port
module phb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/pci_host_bridge_config_shadow.sv =====
// host bridge configuration space with e-segment shadow map
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+-----------------------------------------------------
//  req     | in  | valid/ready | req_type, func_num, reg_addr, wdata
//  rsp     | out | valid/ready | rdata, seg_read_internal, seg_write_internal, map_updated
//
// the byte ram is read on the accepting edge; modify, write back and the load of the
// response register happen on the edge where the read stage moves on, held off while the
// response is stalled. one transaction per cycle is sustained while responses are taken; a write
// is forwarded to a read of the same byte accepted on the edge where the write is stored.
// reset clears per-byte valid bits, so unwritten bytes read their defaults; no clearing pass.
// a stalled response holds, and req.ready drops while both stages are full and the
// response is stalled.
module pci_host_bridge_config_shadow (
	input  logic          clk,
	input  logic          arst_n,
	phb_req_if.sink       req,
	phb_rsp_if.source     rsp
);

	logic                                     acc;
	logic                                     s1_adv;
	logic                                     s1_move;

	logic                                     s1_valid_q;
	logic                                     type_s1;
	logic [2:0]                               func_s1;
	logic [phb_pkg::ADDR_W-1:0]               addr_s1;
	logic [phb_pkg::DATA_W-1:0]               wdata_s1;
	logic                                     vld_s1;
	logic                                     fwd_hit_s1;
	logic [phb_pkg::DATA_W-1:0]               fwd_data_s1;

	logic [phb_pkg::DEPTH-1:0]                vld_q;
	logic [phb_pkg::DATA_W-1:0]               reg53_q;
	logic [2*phb_pkg::SEG_W-1:0]              map_q;

	logic                                     out_valid_q;
	logic [phb_pkg::DATA_W-1:0]               rdata_q;
	logic                                     upd_q;

	logic [phb_pkg::DATA_W-1:0]               ram_rdata;
	logic [phb_pkg::DATA_W-1:0]               cur_byte;
	logic [phb_pkg::DATA_W-1:0]               new_byte;
	logic [phb_pkg::DATA_W-1:0]               rdata_n;
	logic [2*phb_pkg::SEG_W-1:0]              map_n;
	phb_pkg::wr_filt_t                        filt;
	logic                                     is_wr;
	logic                                     ram_we;
	logic                                     upd;

	// handshake
	assign s1_adv    = !out_valid_q || rsp.ready;
	assign s1_move   = s1_valid_q && s1_adv;
	assign req.ready = !s1_valid_q || s1_adv;
	assign acc       = req.valid && req.ready;

	// byte store
	phb_ram #(
		.WIDTH (phb_pkg::DATA_W),
		.DEPTH (phb_pkg::DEPTH)
	) u_cfg_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_s1),
		.wdata (new_byte),
		.re    (acc),
		.raddr (req.reg_addr),
		.rdata (ram_rdata)
	);

	// current byte: forwarded write, stored byte or reset default
	always_comb begin
		if (fwd_hit_s1) begin
			cur_byte = fwd_data_s1;
		end else if (vld_s1) begin
			cur_byte = ram_rdata;
		end else begin
			cur_byte = phb_pkg::reset_byte(addr_s1);
		end
	end

	// modify step
	always_comb begin
		is_wr    = (func_s1 == 3'd0) && (type_s1 == phb_pkg::REQ_WRITE);
		filt     = phb_pkg::write_filter(addr_s1, wdata_s1);
		ram_we   = s1_move && is_wr && filt.store;
		new_byte = (is_wr && filt.store) ? filt.value : cur_byte;
		upd      = is_wr && (addr_s1 == phb_pkg::ADDR_SHADOW) &&
			((cur_byte & wdata_s1) != phb_pkg::SHADOW_KEEP);
		map_n    = upd ? phb_pkg::build_map(reg53_q[6:5], wdata_s1[7:4]) : map_q;
		rdata_n  = (func_s1 != 3'd0) ? phb_pkg::FUNC_ABSENT_DATA : new_byte;
	end

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			type_s1     <= req.req_type;
			func_s1     <= req.func_num;
			addr_s1     <= req.reg_addr;
			wdata_s1    <= req.wdata;
			vld_s1      <= vld_q[req.reg_addr];
			fwd_hit_s1  <= ram_we && (addr_s1 == req.reg_addr);
			fwd_data_s1 <= new_byte;
		end
	end

	// written-byte flags, mode mirror and shadow map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			reg53_q <= phb_pkg::reset_byte(phb_pkg::ADDR_CFG53);
			map_q   <= '0;
		end else if (s1_move) begin
			if (ram_we) begin
				vld_q[addr_s1] <= 1'b1;
			end
			if (ram_we && (addr_s1 == phb_pkg::ADDR_CFG53)) begin
				reg53_q <= new_byte;
			end
			map_q <= map_n;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			rdata_q <= rdata_n;
			upd_q   <= upd;
		end
	end

	assign rsp.valid              = out_valid_q;
	assign rsp.rdata              = rdata_q;
	assign rsp.seg_read_internal  = map_q[phb_pkg::SEG_W-1:0];
	assign rsp.seg_write_internal = map_q[2*phb_pkg::SEG_W-1:phb_pkg::SEG_W];
	assign rsp.map_updated        = upd_q;

endmodule

// ===== rtl/phb_checker.sv =====
// port-level checks of the host bridge config space, bound to the top level
`include "pci_host_bridge_config_shadow_defines.svh"

module phb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] rsp_rdata,
	input logic [3:0] rsp_seg_read_internal,
	input logic [3:0] rsp_seg_write_internal
);

	// a stalled response keeps its byte
	`PHB_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_rdata), "stalled response changed")

	// an accepted transaction has a response waiting once it has passed the read stage
	`PHB_ASSERT_TWO(a_rsp_latency, req_valid && req_ready, rsp_valid, "response missing after accepted transaction")

	// the request side only stalls behind a pending response
	`PHB_ASSERT_NOW(a_stall_cause, !req_ready, rsp_valid, "request stalled with no pending response")

	// all enabled segments share one mode, so the two maps agree or one is empty
	`PHB_ASSERT_NOW(a_map_shape, rsp_valid, (rsp_seg_read_internal == rsp_seg_write_internal) || (rsp_seg_read_internal == 4'd0) || (rsp_seg_write_internal == 4'd0), "inconsistent shadow map")

endmodule

bind pci_host_bridge_config_shadow phb_checker u_phb_checker (
	.clk                    (clk),
	.arst_n                 (arst_n),
	.req_valid              (req.valid),
	.req_ready              (req.ready),
	.rsp_valid              (rsp.valid),
	.rsp_ready              (rsp.ready),
	.rsp_rdata              (rsp.rdata),
	.rsp_seg_read_internal  (rsp.seg_read_internal),
	.rsp_seg_write_internal (rsp.seg_write_internal)
);

// ===== verif/tb_top.sv =====
// self-checking testbench for the host bridge configuration space and its shadow map
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import phb_pkg::*;

	localparam int TOTAL_ACCESSES = 1350;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int IDLE_PERCENT   = 25;

	// one configuration access as presented on the request channel
	typedef struct {
		req_kind_t         kind;
		logic [2:0]        func;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
	} access_t;

	// one response as seen on the response channel
	typedef struct {
		logic [DATA_W-1:0] rdata;
		logic [SEG_W-1:0]  rd_int;
		logic [SEG_W-1:0]  wr_int;
		logic              updated;
	} bridge_rsp_t;

	logic clk;
	logic arst_n;

	phb_req_if req_if ();
	phb_rsp_if rsp_if ();

	pci_host_bridge_config_shadow i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// predicted configuration space and shadow map
	logic [DATA_W-1:0]  cfg_space [DEPTH];
	logic [2*SEG_W-1:0] seg_map;

	access_t     pending_accesses [$];
	bridge_rsp_t expected_rsps [$];

	int   error_cnt;
	int   accepted_cnt;
	int   activity_cnt;
	logic req_fire;
	logic no_idle;

	// stretch of transactions with both sides running flat out
	assign no_idle = (accepted_cnt >= 400) && (accepted_cnt < 650);

	always #1 clk = ~clk;

	// predict one access, updating the shadow copy of the space
	function automatic bridge_rsp_t bridge_access(input access_t acc);
		bridge_rsp_t r;
		logic [DATA_W-1:0] v;
		logic ro;
		shadow_mode_t mode;
		logic [SEG_W-1:0] rd;
		logic [SEG_W-1:0] wr;
		r.updated = 1'b0;
		if (acc.func != 3'd0) begin
			r.rdata = FUNC_ABSENT_DATA;
		end else begin
			if (acc.kind == REQ_WRITE) begin
				v = acc.data;
				ro = (acc.addr <= ADDR_DID_HI) || (acc.addr >= ADDR_REV && acc.addr <= ADDR_CLS)
					|| (acc.addr == ADDR_HDR)
					|| (acc.addr >= ADDR_RO_LO && acc.addr <= ADDR_RO_HI);
				case (acc.addr)
					ADDR_CMD_LO: v = (v & 8'h42) | 8'h04;
					ADDR_CMD_HI: v = v & 8'h01;
					ADDR_STS_LO: v = '0;
					ADDR_STS_HI: v = 8'h02;
					ADDR_SHADOW: begin
						// map is left alone when old and new overlap in exactly f0
						if ((cfg_space[ADDR_SHADOW] & v) != SHADOW_KEEP) begin
							rd = '0;
							wr = '0;
							mode = shadow_mode_t'(cfg_space[ADDR_CFG53][6:5]);
							for (int d = 0; d < SEG_W; d++) begin
								if (d < SHADOW_SEGMENTS && v[d+4]) begin
									case (mode)
										MODE_REXT_WINT: wr[d] = 1'b1;
										MODE_RINT_WINT: begin
											rd[d] = 1'b1;
											wr[d] = 1'b1;
										end
										MODE_RINT_WEXT: rd[d] = 1'b1;
										default: ;
									endcase
								end
							end
							seg_map = {wr, rd};
							r.updated = 1'b1;
						end
					end
					default: ;
				endcase
				if (!ro) begin
					cfg_space[acc.addr] = v;
				end
			end
			r.rdata = cfg_space[acc.addr];
		end
		r.rd_int = seg_map[SEG_W-1:0];
		r.wr_int = seg_map[2*SEG_W-1:SEG_W];
		return r;
	endfunction

	function automatic void push_access(input req_kind_t kind, input logic [2:0] func,
			input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		access_t a;
		a.kind = kind;
		a.func = func;
		a.addr = addr;
		a.data = data;
		pending_accesses.push_back(a);
	endfunction

	// request driver, fed from the pending queue
	always @(negedge clk) begin : req_driver
		access_t nxt;
		logic drive;
		if (arst_n) begin
			if (!req_if.valid || req_fire) begin
				drive = 1'b0;
				if (pending_accesses.size() != 0
						&& (no_idle || $urandom_range(99) >= IDLE_PERCENT)) begin
					nxt = pending_accesses.pop_front();
					drive = 1'b1;
					req_if.req_type <= nxt.kind;
					req_if.func_num <= nxt.func;
					req_if.reg_addr <= nxt.addr;
					req_if.wdata    <= nxt.data;
				end
				req_if.valid <= drive;
			end
			rsp_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	// monitor: check responses, predict accepted requests
	always @(posedge clk) begin : monitor
		bridge_rsp_t want;
		access_t acc;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (expected_rsps.size() == 0) begin
					$error("response with no access outstanding: rdata %0h", rsp_if.rdata);
					error_cnt++;
				end else begin
					want = expected_rsps.pop_front();
					if (rsp_if.rdata !== want.rdata) begin
						$error("rdata: expected %0h, got %0h", want.rdata, rsp_if.rdata);
						error_cnt++;
					end
					if (rsp_if.seg_read_internal !== want.rd_int) begin
						$error("seg_read_internal: expected %0h, got %0h", want.rd_int,
							rsp_if.seg_read_internal);
						error_cnt++;
					end
					if (rsp_if.seg_write_internal !== want.wr_int) begin
						$error("seg_write_internal: expected %0h, got %0h", want.wr_int,
							rsp_if.seg_write_internal);
						error_cnt++;
					end
					if (rsp_if.map_updated !== want.updated) begin
						$error("map_updated: expected %0h, got %0h", want.updated,
							rsp_if.map_updated);
						error_cnt++;
					end
				end
			end
			if (req_if.valid && req_if.ready) begin
				acc.kind = req_kind_t'(req_if.req_type);
				acc.func = req_if.func_num;
				acc.addr = req_if.reg_addr;
				acc.data = req_if.wdata;
				expected_rsps.push_back(bridge_access(acc));
				accepted_cnt++;
			end
			if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready)) begin
				activity_cnt <= activity_cnt + 1;
			end
		end
		req_fire <= arst_n && req_if.valid && req_if.ready;
	end

	// watchdog on cycles with no transaction on either channel
	initial begin : watchdog
		int stalled;
		int seen;
		stalled = 0;
		seen = 0;
		while (stalled < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (activity_cnt != seen) begin
				seen = activity_cnt;
				stalled = 0;
			end else begin
				stalled++;
			end
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stimulus
		int pick;
		logic [DATA_W-1:0] b;
		clk = 1'b0;
		arst_n = 1'b0;
		req_fire = 1'b0;
		error_cnt = 0;
		accepted_cnt = 0;
		activity_cnt = 0;
		req_if.valid = 1'b0;
		req_if.req_type = REQ_READ;
		req_if.func_num = '0;
		req_if.reg_addr = '0;
		req_if.wdata = '0;
		rsp_if.ready = 1'b0;

		// state after reset
		for (int i = 0; i < DEPTH; i++) begin
			cfg_space[i] = '0;
		end
		cfg_space[ADDR_VID_LO] = 8'h39;
		cfg_space[ADDR_VID_HI] = 8'h10;
		cfg_space[ADDR_DID_LO] = 8'h06;
		cfg_space[ADDR_DID_HI] = 8'h04;
		cfg_space[ADDR_CMD_LO] = 8'h07;
		cfg_space[ADDR_STS_LO] = 8'h80;
		cfg_space[ADDR_STS_HI] = 8'h02;
		cfg_space[ADDR_CLASS]  = 8'h06;
		cfg_space[ADDR_CFG50]  = 8'hBC;
		cfg_space[ADDR_CFG51]  = 8'hFB;
		cfg_space[ADDR_CFG52]  = 8'hAD;
		cfg_space[ADDR_CFG53]  = 8'hFE;
		seg_map = '0;

		// identification, read-only ranges and command/status forcing
		push_access(REQ_READ,  3'd0, ADDR_VID_LO, 8'h00);
		push_access(REQ_WRITE, 3'd0, ADDR_VID_LO, 8'hFF);
		push_access(REQ_READ,  3'd0, ADDR_CLASS,  8'hFF);
		push_access(REQ_WRITE, 3'd0, ADDR_CMD_LO, 8'hFF);
		push_access(REQ_WRITE, 3'd0, ADDR_CMD_LO, 8'h00);
		push_access(REQ_WRITE, 3'd0, ADDR_CMD_HI, 8'hFF);
		push_access(REQ_WRITE, 3'd0, ADDR_STS_LO, 8'hFF);
		push_access(REQ_WRITE, 3'd0, ADDR_STS_HI, 8'h00);
		push_access(REQ_WRITE, 3'd0, ADDR_RO_LO,  8'hAA);
		push_access(REQ_WRITE, 3'd0, ADDR_RO_HI,  8'h55);
		push_access(REQ_WRITE, 3'd0, 8'h4F,       8'hA5);
		push_access(REQ_WRITE, 3'd0, 8'h0D,       8'h5A);
		push_access(REQ_WRITE, 3'd0, 8'hFF,       8'h00);
		push_access(REQ_READ,  3'd0, 8'hFF,       8'h00);
		// absent functions
		push_access(REQ_WRITE, 3'd7, ADDR_SHADOW, 8'hFF);
		push_access(REQ_READ,  3'd1, ADDR_VID_LO, 8'h00);
		// every shadow mode, and the overlap that leaves the map alone
		push_access(REQ_WRITE, 3'd0, ADDR_CFG53,  8'h00);
		push_access(REQ_WRITE, 3'd0, ADDR_SHADOW, 8'hF0);
		push_access(REQ_WRITE, 3'd0, ADDR_SHADOW, 8'hF0);
		push_access(REQ_WRITE, 3'd0, ADDR_SHADOW, 8'hFF);
		push_access(REQ_WRITE, 3'd0, ADDR_CFG53,  8'h20);
		push_access(REQ_WRITE, 3'd0, ADDR_SHADOW, 8'h50);
		push_access(REQ_WRITE, 3'd0, ADDR_CFG53,  8'h40);
		push_access(REQ_WRITE, 3'd0, ADDR_SHADOW, 8'hA0);
		push_access(REQ_WRITE, 3'd0, ADDR_CFG53,  8'h60);
		push_access(REQ_WRITE, 3'd0, ADDR_SHADOW, 8'hF5);
		push_access(REQ_WRITE, 3'd0, ADDR_SHADOW, 8'h00);
		push_access(REQ_READ,  3'd0, ADDR_SHADOW, 8'h00);

		// random part, weighted towards shadow mode/enable sequences
		while (pending_accesses.size() < TOTAL_ACCESSES) begin
			pick = $urandom_range(99);
			if (pick < 15) begin
				push_access(req_kind_t'($urandom_range(1)), 3'($urandom_range(7, 1)),
					8'($urandom), 8'($urandom));
			end else if (pick < 35) begin
				push_access(req_kind_t'($urandom_range(1)), 3'd0, 8'($urandom), 8'($urandom));
			end else if (pick < 55) begin
				// header bytes and the chipset registers around them
				b = ($urandom_range(1) != 0) ? 8'($urandom_range(15))
					: 8'($urandom_range(8'h55, 8'h4C));
				push_access(req_kind_t'($urandom_range(1)), 3'd0, b, 8'($urandom));
			end else begin
				// set a mode, then one or two enable writes, then maybe a read back
				push_access(REQ_WRITE, 3'd0, ADDR_CFG53, 8'($urandom));
				for (int k = 0; k < $urandom_range(2, 1); k++) begin
					b = 8'($urandom);
					if ($urandom_range(99) < 40) begin
						b[7:4] = 4'hF;
					end
					push_access(REQ_WRITE, 3'd0, ADDR_SHADOW, b);
				end
				if ($urandom_range(1) != 0) begin
					push_access(REQ_READ, 3'd0,
						($urandom_range(1) != 0) ? ADDR_SHADOW : ADDR_CFG53, 8'($urandom));
				end
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for every access to be taken and answered
		while (pending_accesses.size() != 0 || req_if.valid || expected_rsps.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_cnt == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/phb_pkg.sv
rtl/phb_req_if.sv
rtl/phb_rsp_if.sv
rtl/phb_ram.sv
rtl/pci_host_bridge_config_shadow.sv
rtl/phb_checker.sv
verif/tb_top.sv
